@@ src/kpp_pkg.sv @@
// Shared types, constants and helper functions for keyframe pose playback.
package kpp_pkg;

  localparam logic signed [20:0] PI_Q     = 21'sd205887;
  localparam logic signed [20:0] TWO_PI_Q = 21'sd411774;

  // Shared divider widths: play time is at most 57 bits, trace length 43 bits.
  localparam int DIV_DW = 57;
  localparam int DIV_VW = 43;

  localparam logic [2:0] REG_POS_GAIN       = 3'd0;
  localparam logic [2:0] REG_HEIGHT_OFFSET  = 3'd1;
  localparam logic [2:0] REG_SPEED_GAIN     = 3'd2;
  localparam logic [2:0] REG_LOOP_ENABLE    = 3'd3;
  localparam logic [2:0] REG_START_DELAY    = 3'd4;
  localparam logic [2:0] REG_FRAME_INTERVAL = 3'd5;
  localparam logic [2:0] REG_FRAME_COUNT    = 3'd6;

  typedef struct packed {
    logic               present;
    logic signed [18:0] yaw;
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } entry_t;

  typedef struct packed {
    logic start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DIV_DW-1:0] quotient;
    logic [DIV_VW-1:0] remainder;
  } div_rsp_t;

  function automatic logic signed [20:0] wrap_pi(input logic signed [20:0] a);
    logic signed [20:0] r;
    r = a;
    if (a > PI_Q) r = a - TWO_PI_Q;
    else if (a < -PI_Q) r = a + TWO_PI_Q;
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [44:0] v);
    logic [31:0] r;
    r = v[31:0];
    if (v > 45'sd2147483647) r = 32'h7fffffff;
    else if (v < -45'sd2147483648) r = 32'h80000000;
    return r;
  endfunction

endpackage

@@ src/kpp_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module kpp_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/kpp_div.sv @@
// Restoring divider, one quotient bit per cycle.
module kpp_div (
  input  logic                clk,
  input  logic                rst,
  input  kpp_pkg::div_req_t   req,
  output kpp_pkg::div_rsp_t   rsp
);
  import kpp_pkg::*;

  localparam int CNTW = $clog2(DIV_DW + 1);

  logic              busy;
  logic              done;
  logic [CNTW-1:0]   cnt;
  logic [DIV_DW-1:0] quo;
  logic [DIV_VW-1:0] rem;
  logic [DIV_VW-1:0] dvs;
  logic [DIV_VW:0]   trial;
  logic              ge;
  logic [DIV_VW:0]   rem_next;

  assign trial    = {rem, quo[DIV_DW-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign rem_next = ge ? trial - {1'b0, dvs} : trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DIV_DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_DW-2:0], ge};
      rem <= rem_next[DIV_VW-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;
endmodule

@@ src/keyframe_pose_playback.sv @@
// Keyframe pose playback top level: table, sequencer, shared divider and shared multiplier.
//
//  channel  | dir | handshake                 | payload
//  s_*      | in  | s_tvalid / s_tready       | s_tdata keyframe or time, s_tuser func
//  m_*      | out | m_tvalid / m_tready       | m_tdata pose, m_tlast end of tick
//  cfg_*    | in  | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// A load request is written to the table while the block stays idle, so s_tready
// stays high. A tick forms play time with the shared multiplier, then makes passes
// of the shared 57-step divider (three passes with looping on, two with it off,
// none before start or with a zero interval), then interpolates each present
// object and skips each absent one. After reset a clearing pass writes all
// MAX_FRAMES * MAX_OBJECTS table entries before s_tready rises. A held output
// stalls the sequencer only when a finished pose waits behind the one on m_tdata.
module keyframe_pose_playback #(
  parameter int MAX_FRAMES  = 1024,
  parameter int MAX_OBJECTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // frame_index, object_id, pos_x, pos_y, pos_z, heading, now_us, zero pad
  input  logic [183:0] s_tdata,
  // func
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_id, out_x, out_y, out_z, out_yaw, zero pad
  output logic [119:0] m_tdata,
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import kpp_pkg::*;

  localparam int DEPTH = MAX_FRAMES * MAX_OBJECTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = $clog2(MAX_FRAMES);
  localparam int CW    = $clog2(MAX_FRAMES + 1);
  localparam int IDW   = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

  localparam logic [4:0] S_IDLE = 5'd0,  S_CLR = 5'd1,  S_TSTART = 5'd2,
                         S_TEL  = 5'd3,  S_MHI = 5'd4,  S_MLO    = 5'd5,
                         S_MTOT = 5'd6,  S_TOT = 5'd7,  S_MODW   = 5'd8,
                         S_QDIV = 5'd9,  S_QW  = 5'd10, S_ADIV   = 5'd11,
                         S_AW   = 5'd12, S_OF0 = 5'd13, S_OS0    = 5'd14,
                         S_OS1  = 5'd15, S_OLAT = 5'd16, S_OMUL  = 5'd17,
                         S_OEMIT = 5'd18, S_ONEXT = 5'd19, S_OEND = 5'd20;

  // Configuration registers.
  logic [23:0]        pos_gain;
  logic signed [31:0] height_offset;
  logic [23:0]        speed_gain;
  logic               loop_enable;
  logic [31:0]        start_delay_us;
  logic [31:0]        frame_interval_us;
  logic [10:0]        frame_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_gain          <= 24'd3277;
      height_offset     <= 32'sd131072;
      speed_gain        <= 24'd65536;
      loop_enable       <= 1'b1;
      start_delay_us    <= 32'd500000;
      frame_interval_us <= 32'd1000000;
      frame_count       <= 11'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POS_GAIN:       pos_gain          <= cfg_data[23:0];
        REG_HEIGHT_OFFSET:  height_offset     <= cfg_data;
        REG_SPEED_GAIN:     speed_gain        <= cfg_data[23:0];
        REG_LOOP_ENABLE:    loop_enable       <= cfg_data[0];
        REG_START_DELAY:    start_delay_us    <= cfg_data;
        REG_FRAME_INTERVAL: frame_interval_us <= cfg_data;
        REG_FRAME_COUNT:    frame_count       <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [9:0]         in_frame;
  logic [3:0]         in_obj;
  logic [47:0]        in_now;
  entry_t             in_entry;

  assign in_frame          = s_tdata[9:0];
  assign in_obj            = s_tdata[13:10];
  assign in_entry.x        = s_tdata[45:14];
  assign in_entry.y        = s_tdata[77:46];
  assign in_entry.z        = s_tdata[109:78];
  assign in_entry.yaw      = s_tdata[128:110];
  assign in_entry.present  = 1'b1;
  assign in_now            = s_tdata[176:129];

  logic [4:0]  state;
  logic [AW-1:0] clr_cnt;
  logic        started;
  logic [47:0] start_us;
  logic [47:0] now_r;
  logic [47:0] el;
  logic [55:0] play_hi;
  logic [DIV_DW-1:0] play;
  logic [32:0] local_t;
  logic [FW-1:0] idx0;
  logic [16:0] alpha;
  logic [IDW-1:0] id;
  logic [2:0]  step;
  entry_t      e0, e1;
  logic [31:0] xi, yi, zi;
  logic [31:0] ox, oy, oz;
  logic signed [20:0] oyaw;
  logic        pend_v;
  logic [3:0]  pend_id;
  logic [31:0] pend_x, pend_y, pend_z;
  logic [18:0] pend_yaw;

  logic        s_fire;
  logic        load_ok;
  logic [AW-1:0] load_addr;
  assign s_tready  = (state == S_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign load_ok   = (32'(in_frame) < 32'(MAX_FRAMES)) && (32'(in_obj) < 32'(MAX_OBJECTS));
  assign load_addr = AW'(32'(in_frame) * MAX_OBJECTS + 32'(in_obj));

  // Effective frame count, held to 2..MAX_FRAMES.
  logic [CW-1:0] fc_eff, fcm1, fcm2;
  always_comb begin
    if (frame_count < 11'd2) fc_eff = CW'(2);
    else if (32'(frame_count) > 32'(MAX_FRAMES)) fc_eff = CW'(MAX_FRAMES);
    else fc_eff = CW'(frame_count);
  end
  assign fcm1 = fc_eff - CW'(1);
  assign fcm2 = fc_eff - CW'(2);

  // Keyframe table.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;
  logic [AW-1:0] s0_addr, s1_addr;

  assign ram_we    = (state == S_CLR) || (s_fire && !s_tuser && load_ok);
  assign ram_waddr = (state == S_CLR) ? clr_cnt : load_addr;
  assign ram_wdata = (state == S_CLR) ? '0 : in_entry;
  assign s0_addr   = AW'(32'(idx0) * MAX_OBJECTS + 32'(id));
  assign s1_addr   = AW'((32'(idx0) + 32'd1) * MAX_OBJECTS + 32'(id));

  always_comb begin
    case (state)
      S_OF0:   ram_raddr = AW'(id);
      S_OS0:   ram_raddr = s0_addr;
      S_OS1:   ram_raddr = s1_addr;
      default: ram_raddr = s0_addr;
    endcase
  end

  kpp_ram #(.W($bits(entry_t)), .DEPTH(DEPTH)) u_table (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // Shared divider. The trace length comes straight from the product register.
  div_req_t div_req;
  div_rsp_t div_rsp;
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = play;
    div_req.divisor  = DIV_VW'(frame_interval_us);
    case (state)
      S_TOT: begin
        div_req.start   = loop_enable;
        div_req.divisor = prod[DIV_VW-1:0];
      end
      S_QDIV: div_req.start = 1'b1;
      S_ADIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_DW'({local_t, 16'd0});
      end
      default: ;
    endcase
  end

  kpp_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // Shared multiplier with a registered product.
  logic signed [33:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [59:0] prod;
  logic signed [59:0] prod_r;
  logic signed [43:0] rnd;
  logic signed [20:0] dyaw;
  logic signed [20:0] yaw_sum;

  assign prod_r  = prod + 60'sd32768;
  assign rnd     = prod_r[59:16];
  assign dyaw    = wrap_pi(21'(e1.yaw) - 21'(e0.yaw));
  assign yaw_sum = wrap_pi(21'(e0.yaw) + rnd[20:0]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MHI: begin
        mul_a = {10'd0, el[47:24]};
        mul_b = {2'd0, speed_gain};
      end
      S_MLO: begin
        mul_a = {10'd0, el[23:0]};
        mul_b = {2'd0, speed_gain};
      end
      S_MTOT: begin
        mul_a = {2'd0, frame_interval_us};
        mul_b = {{(26-CW){1'b0}}, fcm1};
      end
      S_OMUL: begin
        mul_b = {9'd0, alpha};
        case (step)
          3'd0: mul_a = 34'(e1.x) - 34'(e0.x);
          3'd1: mul_a = 34'(e1.y) - 34'(e0.y);
          3'd2: mul_a = 34'(e1.z) - 34'(e0.z);
          3'd3: mul_a = 34'(dyaw);
          3'd4: mul_a = 34'(signed'(xi));
          3'd5: mul_a = 34'(signed'(yi));
          3'd6: mul_a = 34'(signed'(zi));
          default: mul_a = '0;
        endcase
        if (step >= 3'd4) mul_b = {2'd0, pos_gain};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_cnt  <= '0;
      started  <= 1'b0;
      start_us <= '0;
      pend_v   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_fire && s_tuser) begin
            now_r <= in_now;
            state <= S_TSTART;
          end
        end
        S_TSTART: begin
          if (!started) begin
            started <= 1'b1;
            if ({1'b0, now_r} + 49'(start_delay_us) > 49'h0_ffff_ffff_ffff) begin
              start_us <= 48'hffff_ffff_ffff;
            end else begin
              start_us <= now_r + 48'(start_delay_us);
            end
          end
          state <= S_TEL;
        end
        S_TEL: begin
          id <= '0;
          if (now_r < start_us) begin
            idx0  <= '0;
            alpha <= '0;
            state <= S_OF0;
          end else if (frame_interval_us == 32'd0) begin
            idx0  <= FW'(fcm2);
            alpha <= '0;
            state <= S_OF0;
          end else begin
            el    <= now_r - start_us;
            state <= S_MHI;
          end
        end
        S_MHI: state <= S_MLO;
        S_MLO: begin
          play_hi <= {prod[47:0], 8'd0};
          state   <= S_MTOT;
        end
        S_MTOT: begin
          play  <= DIV_DW'(play_hi) + DIV_DW'(prod[47:16]);
          state <= S_TOT;
        end
        S_TOT: begin
          if (loop_enable) begin
            state <= S_MODW;
          end else begin
            if (play > DIV_DW'(prod[DIV_VW-1:0])) play <= DIV_DW'(prod[DIV_VW-1:0]);
            state <= S_QDIV;
          end
        end
        S_MODW: begin
          if (div_rsp.done) begin
            play  <= DIV_DW'(div_rsp.remainder);
            state <= S_QDIV;
          end
        end
        S_QDIV: state <= S_QW;
        S_QW: begin
          if (div_rsp.done) begin
            // A play time right at the end of the trace keeps the last pair.
            if (div_rsp.quotient >= DIV_DW'(fcm1)) begin
              idx0    <= FW'(fcm2);
              local_t <= 33'(div_rsp.remainder) + 33'(frame_interval_us);
            end else begin
              idx0    <= FW'(div_rsp.quotient);
              local_t <= 33'(div_rsp.remainder);
            end
            state <= S_ADIV;
          end
        end
        S_ADIV: state <= S_AW;
        S_AW: begin
          if (div_rsp.done) begin
            alpha <= (div_rsp.quotient > DIV_DW'(65536)) ? 17'd65536
                                                        : div_rsp.quotient[16:0];
            state <= S_OF0;
          end
        end
        S_OF0: state <= S_OS0;
        S_OS0: state <= ram_rdata.present ? S_OS1 : S_ONEXT;
        S_OS1: begin
          e0    <= ram_rdata;
          state <= ram_rdata.present ? S_OLAT : S_ONEXT;
        end
        S_OLAT: begin
          e1    <= ram_rdata.present ? ram_rdata : e0;
          step  <= '0;
          state <= S_OMUL;
        end
        S_OMUL: begin
          step <= step + 1'b1;
          case (step)
            3'd1: xi <= e0.x + rnd[31:0];
            3'd2: yi <= e0.y + rnd[31:0];
            3'd3: zi <= e0.z + rnd[31:0];
            3'd4: oyaw <= yaw_sum;
            3'd5: ox <= sat32({rnd[43], rnd});
            3'd6: oy <= sat32({rnd[43], rnd});
            3'd7: begin
              oz    <= sat32({rnd[43], rnd} + 45'(height_offset));
              state <= S_OEMIT;
            end
            default: ;
          endcase
        end
        S_OEMIT: begin
          // One pose waits in the pending slot until the next one shows
          // whether it was the last of the tick.
          if (!pend_v || !m_tvalid) begin
            if (pend_v) begin
              m_tdata  <= {1'b0, pend_yaw, pend_z, pend_y, pend_x, pend_id};
              m_tlast  <= 1'b0;
              m_tvalid <= 1'b1;
            end
            pend_v   <= 1'b1;
            pend_id  <= 4'(id);
            pend_x   <= ox;
            pend_y   <= oy;
            pend_z   <= oz;
            pend_yaw <= oyaw[18:0];
            state    <= S_ONEXT;
          end
        end
        S_ONEXT: begin
          if (id == IDW'(MAX_OBJECTS - 1)) begin
            state <= S_OEND;
          end else begin
            id    <= id + 1'b1;
            state <= S_OF0;
          end
        end
        S_OEND: begin
          if (!pend_v) begin
            state <= S_IDLE;
          end else if (!m_tvalid) begin
            m_tdata  <= {1'b0, pend_yaw, pend_z, pend_y, pend_x, pend_id};
            m_tlast  <= 1'b1;
            m_tvalid <= 1'b1;
            pend_v   <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ src/kpp_chk.sv @@
// Port-level assertions for keyframe pose playback, bound to the top level.
module kpp_chk (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [119:0] m_tdata,
  input logic         m_tlast
);
  // A stalled pose holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // A tick request keeps the block busy on the next cycle.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("tick did not occupy the block");

  // A load request leaves the input ready on the next cycle.
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> s_tready)
    else $error("load request stalled the input");

  // Nothing follows the last pose of a tick right away.
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid)
    else $error("pose followed the end of a tick");
endmodule

bind keyframe_pose_playback kpp_chk u_kpp_chk (.*);
